// ----- rtl/bitmap_glyph_row_renderer_assert.svh -----
// assertion macros shared by the renderer checks
`ifndef BITMAP_GLYPH_ROW_RENDERER_ASSERT_SVH
`define BITMAP_GLYPH_ROW_RENDERER_ASSERT_SVH

// same-cycle implication, off during reset
`define BGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bgr_pkg.sv -----
// shared types and constants of the glyph row renderer
`timescale 1ns / 1ps
`default_nettype none
package bgr_pkg;

  localparam int GLYPH_WIDTH  = 10;
  localparam int GLYPH_HEIGHT = 14;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;

  localparam int GLYPH_COUNT = int'(LAST_CODE) - int'(FIRST_CODE) + 1;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int CODE_W = 8;
  localparam int LROW_W = 4;
  localparam int PIX_W  = 10;
  localparam int COL_W  = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // one queued command: a store write or a glyph draw
  typedef struct packed {
    logic             is_draw;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  bits;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [COL_W-1:0]  ink;
    logic [COL_W-1:0]  paper;
    logic              erase;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/bitmap_glyph_row_renderer.sv -----
// a draw taken with the queue empty passes the queue, command register and store
//   read register before its first row; a load is one store write; a draw holds
//   the back end: a fetch, then one row per cycle unless stalled (single read port)
// input side takes words while the two-entry queue has room, even under output stall
// reset (synchronous, active low) clears queue, sequencer and output valid;
//   the glyph store is not cleared and holds garbage until loaded
`timescale 1ns / 1ps
`default_nettype none
module bitmap_glyph_row_renderer #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [bgr_pkg::X_W-1:0]     in_pos_x,
  input  wire logic [bgr_pkg::Y_W-1:0]     in_pos_y,
  input  wire logic [bgr_pkg::CODE_W-1:0]  in_glyph_code,
  input  wire logic [bgr_pkg::LROW_W-1:0]  in_glyph_row,
  input  wire logic [bgr_pkg::PIX_W-1:0]   in_row_bits,
  input  wire logic [bgr_pkg::COL_W-1:0]   in_text_colour,
  input  wire logic [bgr_pkg::COL_W-1:0]   in_fill_colour,
  input  wire logic                        in_erase_enable,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bgr_pkg::X_W-1:0]          out_x,
  output logic [bgr_pkg::Y_W-1:0]          out_y,
  output logic [bgr_pkg::PIX_W-1:0]        out_pixel_bits,
  output logic [bgr_pkg::PIX_W-1:0]        out_write_mask,
  output logic [bgr_pkg::COL_W-1:0]        out_ink_colour,
  output logic [bgr_pkg::COL_W-1:0]        out_paper_colour,
  output logic                             out_last_row
);

  logic          q_push, q_full, q_pop, q_valid;
  bgr_pkg::cmd_t push_cmd, head_cmd;

  bgr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_glyph_code   (in_glyph_code),
    .in_glyph_row    (in_glyph_row),
    .in_row_bits     (in_row_bits),
    .in_text_colour  (in_text_colour),
    .in_fill_colour  (in_fill_colour),
    .in_erase_enable (in_erase_enable),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  bgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  bgr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_pixel_bits   (out_pixel_bits),
    .out_write_mask   (out_write_mask),
    .out_ink_colour   (out_ink_colour),
    .out_paper_colour (out_paper_colour),
    .out_last_row     (out_last_row)
  );

endmodule
`default_nettype wire

// ----- rtl/bgr_ram.sv -----
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bgr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1330
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bgr_queue.sv -----
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module bgr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bgr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bgr_pkg::cmd_t      head_cmd
);

  bgr_pkg::cmd_t                    entry_r [bgr_pkg::QUEUE_DEPTH];
  logic [bgr_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [bgr_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [bgr_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full       = (count_r == bgr_pkg::QCNT_W'(bgr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bgr_front.sv -----
// front end: accepts words, drops the ones without effect, builds commands
`timescale 1ns / 1ps
`default_nettype none
module bgr_front #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic [bgr_pkg::X_W-1:0]      in_pos_x,
  input  wire logic [bgr_pkg::Y_W-1:0]      in_pos_y,
  input  wire logic [bgr_pkg::CODE_W-1:0]   in_glyph_code,
  input  wire logic [bgr_pkg::LROW_W-1:0]   in_glyph_row,
  input  wire logic [bgr_pkg::PIX_W-1:0]    in_row_bits,
  input  wire logic [bgr_pkg::COL_W-1:0]    in_text_colour,
  input  wire logic [bgr_pkg::COL_W-1:0]    in_fill_colour,
  input  wire logic                         in_erase_enable,
  input  wire logic                         q_full,
  output logic                              q_push,
  output bgr_pkg::cmd_t                     q_cmd
);

  localparam logic [bgr_pkg::PIX_W-1:0] ROW_MASK =
    bgr_pkg::PIX_W'((64'd1 << bgr_pkg::GLYPH_WIDTH) - 64'd1);

  logic                         printable, row_ok, on_screen, keep;
  logic [bgr_pkg::CODE_W-1:0]   code_off;
  logic [bgr_pkg::ADDR_W-1:0]   glyph_base;

  assign printable = (in_glyph_code >= bgr_pkg::FIRST_CODE) &&
                     (in_glyph_code <= bgr_pkg::LAST_CODE);
  assign row_ok    = (int'(in_glyph_row) < bgr_pkg::GLYPH_HEIGHT);
  assign on_screen = ({1'b0, in_pos_x} < (bgr_pkg::X_W + 1)'(SCREEN_WIDTH)) &&
                     ({1'b0, in_pos_y} < (bgr_pkg::Y_W + 1)'(SCREEN_HEIGHT));

  assign code_off   = in_glyph_code - bgr_pkg::FIRST_CODE;
  // constant multiply by the glyph height
  assign glyph_base = bgr_pkg::ADDR_W'(code_off) *
                      bgr_pkg::ADDR_W'(bgr_pkg::GLYPH_HEIGHT);

  always_comb begin
    keep = 1'b0;
    unique case (in_op)
      bgr_pkg::OP_LOAD: keep = printable && row_ok;
      bgr_pkg::OP_DRAW: keep = printable && on_screen;
      default:          keep = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.is_draw = (in_op == bgr_pkg::OP_DRAW);
    q_cmd.addr    = (in_op == bgr_pkg::OP_DRAW) ? glyph_base :
                    glyph_base + bgr_pkg::ADDR_W'(in_glyph_row);
    q_cmd.bits    = in_row_bits & ROW_MASK;
    q_cmd.x       = in_pos_x;
    q_cmd.y       = in_pos_y;
    q_cmd.ink     = in_text_colour;
    q_cmd.paper   = in_erase_enable ? in_fill_colour : '0;
    q_cmd.erase   = in_erase_enable;
  end

  // dropped words are still taken, they just never reach the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ----- rtl/bgr_back.sv -----
// back end: executes store writes and walks glyph rows out of the store
`timescale 1ns / 1ps
`default_nettype none
module bgr_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire bgr_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [bgr_pkg::X_W-1:0]        out_x,
  output logic [bgr_pkg::Y_W-1:0]        out_y,
  output logic [bgr_pkg::PIX_W-1:0]      out_pixel_bits,
  output logic [bgr_pkg::PIX_W-1:0]      out_write_mask,
  output logic [bgr_pkg::COL_W-1:0]      out_ink_colour,
  output logic [bgr_pkg::COL_W-1:0]      out_paper_colour,
  output logic                           out_last_row
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } bk_state_t;

  localparam logic [bgr_pkg::ROW_W-1:0] LAST_ROW = bgr_pkg::ROW_W'(bgr_pkg::GLYPH_HEIGHT - 1);
  localparam logic [bgr_pkg::PIX_W-1:0] ROW_MASK =
    bgr_pkg::PIX_W'((64'd1 << bgr_pkg::GLYPH_WIDTH) - 64'd1);

  bk_state_t                     state_r, state_nxt;
  logic [bgr_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bgr_pkg::cmd_t                 cmd_r;
  logic [bgr_pkg::X_W-1:0]       x_r;
  logic [bgr_pkg::Y_W-1:0]       y_r;
  logic [bgr_pkg::COL_W-1:0]     ink_r, paper_r;
  logic                          erase_r, last_r;
  logic                          wr_en, issue, take_draw;
  logic [bgr_pkg::ADDR_W-1:0]    rd_addr;
  logic [bgr_pkg::PIX_W-1:0]     rd_data;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    take_draw = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_draw) begin
            take_draw = 1'b1;
            row_nxt   = '0;
            state_nxt = ST_DRAW;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_DRAW: begin
        // a read is only issued when the output register frees up
        if (!out_valid_r || !out_stall) begin
          issue = 1'b1;
          if (row_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_draw) begin
      cmd_r <= q_cmd;
    end
    if (issue) begin
      x_r     <= cmd_r.x;
      y_r     <= cmd_r.y + bgr_pkg::Y_W'(row_r);
      ink_r   <= cmd_r.ink;
      paper_r <= cmd_r.paper;
      erase_r <= cmd_r.erase;
      last_r  <= (row_r == LAST_ROW);
    end
  end

  assign rd_addr = cmd_r.addr + bgr_pkg::ADDR_W'(row_r);

  // the ram read register doubles as the output pixel register
  bgr_ram #(
    .WIDTH (bgr_pkg::PIX_W),
    .DEPTH (bgr_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_cmd.addr),
    .wr_data (q_cmd.bits),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_x            = x_r;
  assign out_y            = y_r;
  assign out_pixel_bits   = rd_data;
  assign out_write_mask   = erase_r ? ROW_MASK : rd_data;
  assign out_ink_colour   = ink_r;
  assign out_paper_colour = paper_r;
  assign out_last_row     = last_r;

endmodule
`default_nettype wire

// ----- rtl/bgr_checker.sv -----
// port-level checks of the renderer and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_glyph_row_renderer_assert.svh"
module bgr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [bgr_pkg::X_W-1:0]     out_x,
  input wire logic [bgr_pkg::Y_W-1:0]     out_y,
  input wire logic [bgr_pkg::PIX_W-1:0]   out_pixel_bits,
  input wire logic [bgr_pkg::PIX_W-1:0]   out_write_mask,
  input wire logic [bgr_pkg::COL_W-1:0]   out_paper_colour,
  input wire logic                        out_last_row
);

  // a stalled word stays put
  `BGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_y) && $stable(out_pixel_bits), "stalled output word changed")

  // mask is either the glyph row itself or the full row
  `BGR_ASSERT_NOW(a_mask_form, out_valid, (out_write_mask == out_pixel_bits) || (&out_write_mask), "write mask is neither pixels nor all ones")

  // a background colour only comes with erase
  `BGR_ASSERT_NOW(a_paper_erase, out_valid && (out_paper_colour != '0), &out_write_mask, "paper colour without erase mask")

  // rows of one character follow back to back, one line down
  `BGR_ASSERT_NEXT(a_row_step, out_valid && !out_stall && !out_last_row, out_valid && (out_y == bgr_pkg::Y_W'($past(out_y) + 1'b1)) && (out_x == $past(out_x)), "glyph rows not consecutive")

endmodule

bind bitmap_glyph_row_renderer bgr_checker u_bgr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_pixel_bits   (out_pixel_bits),
  .out_write_mask   (out_write_mask),
  .out_paper_colour (out_paper_colour),
  .out_last_row     (out_last_row)
);
`default_nettype wire
